[design/suep_pkg.sv]
// ============================================================================
// suep_pkg
// Shared types and constants of the surface UART event parser.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package suep_pkg;

    // Storage of one open packet.
    localparam int PACKET_BYTES = 6;
    localparam int CNT_W        = $clog2(PACKET_BYTES + 1);
    localparam int IDX_W        = $clog2(PACKET_BYTES);

    // Only the first five bytes of a packet matter for decoding.
    localparam int VIEW_BYTES   = 5;

    localparam logic [7:0] END_MARK    = 8'hFE;
    localparam logic [6:0] BOARD_MASK  = 7'h7F;
    localparam logic [7:0] CLASS_FADER  = 8'h66;  // 'f'
    localparam logic [7:0] CLASS_BUTTON = 8'h62;  // 'b'
    localparam logic [7:0] CLASS_ENCODER = 8'h65; // 'e'

    localparam logic [6:0] BOARD_A = 7'd0;
    localparam logic [6:0] BOARD_B = 7'd1;
    localparam logic [6:0] BOARD_C = 7'd4;
    localparam logic [6:0] BOARD_D = 7'd5;
    localparam logic [6:0] BOARD_E = 7'd8;

    typedef enum logic [1:0] {
        KIND_FADER   = 2'd0,
        KIND_BUTTON  = 2'd1,
        KIND_ENCODER = 2'd2
    } kind_t;

    // A packet that closes on this beat, as the decoder sees it.
    typedef struct packed {
        logic                        close;
        logic [VIEW_BYTES-1:0][7:0]  bytes;
    } close_t;

    typedef struct packed {
        logic [3:0]  board_id;
        logic [1:0]  element_kind;
        logic [7:0]  element_index;
        logic [15:0] element_value;
    } event_t;

endpackage

`default_nettype wire

[design/suep_if.sv]
// ============================================================================
// suep_if
// Valid/ready channels for received bytes and decoded events.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface suep_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface suep_ev_if;
    logic        valid;
    logic        ready;
    logic [3:0]  board_id;
    logic [1:0]  element_kind;
    logic [7:0]  element_index;
    logic [15:0] element_value;

    modport source (output valid, output board_id, output element_kind,
                    output element_index, output element_value, input ready);
    modport sink   (input valid, input board_id, input element_kind,
                    input element_index, input element_value, output ready);
endinterface

`default_nettype wire

[design/suep_assembler.sv]
// ============================================================================
// suep_assembler
// Collects bytes into the open packet and flags the beat on which it closes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module suep_assembler (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire logic [7:0]      rx_byte,
    output suep_pkg::close_t     view
);

    logic [suep_pkg::PACKET_BYTES-1:0][7:0] packet_reg, packet_next;
    logic [suep_pkg::CNT_W-1:0]             count_reg, count_next;
    logic                                   end_pending_reg, end_pending_next;
    logic                                   is_mark;
    logic                                   restart;
    logic                                   room;

    assign is_mark = (rx_byte == suep_pkg::END_MARK);
    // A second end mark closes the packet without a checksum and opens the next.
    assign restart = end_pending_reg && is_mark;
    assign room    = (count_reg < suep_pkg::CNT_W'(suep_pkg::PACKET_BYTES));

    // The checksum byte is part of the packet when it closes; a restarting
    // end mark is not.
    always_comb
    begin
        view.close = end_pending_reg;
        for (int i = 0; i < suep_pkg::VIEW_BYTES; i++)
        begin
            if (!restart && count_reg == suep_pkg::CNT_W'(i))
                view.bytes[i] = rx_byte;
            else
                view.bytes[i] = packet_reg[i];
        end
    end

    always_comb
    begin
        packet_next      = packet_reg;
        count_next       = count_reg;
        end_pending_next = end_pending_reg;
        if (fire)
        begin
            end_pending_next = is_mark;
            if (end_pending_reg)
            begin
                packet_next = '0;
                count_next  = '0;
                if (is_mark)
                begin
                    packet_next[0] = rx_byte;
                    count_next     = suep_pkg::CNT_W'(1);
                end
            end
            else if (room)
            begin
                packet_next[count_reg[suep_pkg::IDX_W-1:0]] = rx_byte;
                count_next = count_reg + suep_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packet_reg      <= '0;
            count_reg       <= '0;
            end_pending_reg <= 1'b0;
        end
        else
        begin
            packet_reg      <= packet_next;
            count_reg       <= count_next;
            end_pending_reg <= end_pending_next;
        end
    end

endmodule

`default_nettype wire

[design/suep_decoder.sv]
// ============================================================================
// suep_decoder
// Decodes a closing packet into a board update or an element event.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module suep_decoder (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             fire,
    input  suep_pkg::close_t      view,
    output logic                  event_valid,
    output suep_pkg::event_t      event_data
);

    logic [3:0]  board_reg, board_next;
    logic [15:0] last_value_reg, last_value_next;
    logic [6:0]  board_num;
    logic        board_ok;
    logic        is_board;
    logic        kind_ok;
    logic [1:0]  kind;

    assign is_board  = (view.bytes[0] == suep_pkg::END_MARK);
    assign board_num = view.bytes[1][6:0] & suep_pkg::BOARD_MASK;
    assign board_ok  = (board_num == suep_pkg::BOARD_A) || (board_num == suep_pkg::BOARD_B)
                    || (board_num == suep_pkg::BOARD_C) || (board_num == suep_pkg::BOARD_D)
                    || (board_num == suep_pkg::BOARD_E);

    always_comb
    begin
        kind_ok = 1'b1;
        kind    = suep_pkg::KIND_FADER;
        unique case (view.bytes[0])
            suep_pkg::CLASS_FADER:   kind = suep_pkg::KIND_FADER;
            suep_pkg::CLASS_BUTTON:  kind = suep_pkg::KIND_BUTTON;
            suep_pkg::CLASS_ENCODER: kind = suep_pkg::KIND_ENCODER;
            default:                 kind_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        board_next      = board_reg;
        last_value_next = last_value_reg;
        if (view.close && is_board)
        begin
            if (board_ok)
                board_next = board_num[3:0];
        end
        else if (view.close)
        begin
            // With neither marker the previous value is reported again.
            if (view.bytes[3] == suep_pkg::END_MARK)
                last_value_next = {8'h00, view.bytes[2]};
            else if (view.bytes[4] == suep_pkg::END_MARK)
                last_value_next = {view.bytes[3], view.bytes[2]};
        end
    end

    assign event_valid              = view.close && !is_board && kind_ok;
    assign event_data.board_id      = board_reg;
    assign event_data.element_kind  = kind;
    assign event_data.element_index = view.bytes[1];
    assign event_data.element_value = last_value_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_reg      <= '0;
            last_value_reg <= '0;
        end
        else if (fire)
        begin
            board_reg      <= board_next;
            last_value_reg <= last_value_next;
        end
    end

endmodule

`default_nettype wire

[design/suep_out_reg.sv]
// ============================================================================
// suep_out_reg
// Result register that holds one event until the sink takes it.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module suep_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  suep_pkg::event_t      event_data,
    output logic                  stall,
    suep_ev_if.source             ev
);

    logic             valid_reg, valid_next;
    suep_pkg::event_t data_reg;

    assign stall = valid_reg && !ev.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (ev.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= event_data;
    end

    assign ev.valid         = valid_reg;
    assign ev.board_id      = data_reg.board_id;
    assign ev.element_kind  = data_reg.element_kind;
    assign ev.element_index = data_reg.element_index;
    assign ev.element_value = data_reg.element_value;

endmodule

`default_nettype wire

[design/surface_uart_event_parser_unit.sv]
// ============================================================================
// surface_uart_event_parser_unit
// Splits received surface bytes into packets and emits element events.
// ============================================================================
// The beat that closes a packet loads its event into the result register.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or is being read in the same cycle.
// Reset: rst_n clears the open packet, the end flag, the board number, the last
// value and both valid flags at once.
`timescale 1ns / 1ps
`default_nettype none

module surface_uart_event_parser_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    suep_rx_if.sink    rx,
    suep_ev_if.source  ev
);

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_byte_reg;
    logic             stall;
    logic             fire;
    logic             take;
    logic             event_valid;
    suep_pkg::close_t view;
    suep_pkg::event_t event_data;

    assign fire     = in_valid_reg && !stall;
    assign rx.ready = !in_valid_reg || !stall;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_byte_reg <= rx.rx_byte;
    end

    suep_assembler u_assembler (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .rx_byte (in_byte_reg),
        .view    (view)
    );

    suep_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .view        (view),
        .event_valid (event_valid),
        .event_data  (event_data)
    );

    suep_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire && event_valid),
        .event_data (event_data),
        .stall      (stall),
        .ev         (ev)
    );

endmodule

`default_nettype wire

[design/suep_checker.sv]
// ============================================================================
// suep_checker
// Port-level checks of the surface UART event parser.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module suep_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rx_valid,
    input wire logic        rx_ready,
    input wire logic        ev_valid,
    input wire logic        ev_ready,
    input wire logic [3:0]  board_id,
    input wire logic [1:0]  element_kind
);

    // A held event stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=> ev_valid)
        else $error("event dropped while stalled");

    // A new event follows a byte beat that passed the input register and the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ev_valid) |-> $past(rx_valid && rx_ready, 2))
        else $error("event without a causing byte beat");

    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> (element_kind == suep_pkg::KIND_FADER)
                  || (element_kind == suep_pkg::KIND_BUTTON)
                  || (element_kind == suep_pkg::KIND_ENCODER))
        else $error("illegal element kind");

    assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid |-> (board_id == 4'd0) || (board_id == 4'd1) || (board_id == 4'd4)
                  || (board_id == 4'd5) || (board_id == 4'd8))
        else $error("illegal board number");

endmodule

bind surface_uart_event_parser_unit suep_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rx_valid     (rx.valid),
    .rx_ready     (rx.ready),
    .ev_valid     (ev.valid),
    .ev_ready     (ev.ready),
    .board_id     (ev.board_id),
    .element_kind (ev.element_kind)
);

`default_nettype wire
